>>> sv/broadcast_operand_index_generator_defines.svh
// Assertion macros shared by the broadcast operand index generator
`ifndef BROADCAST_OPERAND_INDEX_GENERATOR_DEFINES_SVH
`define BROADCAST_OPERAND_INDEX_GENERATOR_DEFINES_SVH

// same-cycle implication
`define BOB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BOB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bob_pkg.sv
// Shared constants for the broadcast operand index generator
package bob_pkg;

    localparam int IDX_W        = 48;
    localparam int SLICE_W      = 16;
    localparam int CFG_W        = 64;
    localparam int RANK_W       = 3;
    localparam int PADDR_W      = 5;
    localparam int STEP_BITS    = 4;
    localparam int MAX_RANK_DEF = 4;
    localparam int DIM_BITS_DEF = 16;

    localparam logic [CFG_W-1:0] DIMS_RESET = 64'h0001_0001_0001_0001;

    localparam logic [1:0] REG_LEFT_DIMS  = 2'd0;
    localparam logic [1:0] REG_RIGHT_DIMS = 2'd1;
    localparam logic [1:0] REG_LEFT_RANK  = 2'd2;
    localparam logic [1:0] REG_RIGHT_RANK = 2'd3;

endpackage

>>> sv/bob_regs.sv
// Configuration registers and derived shape, stride and count pipeline
module bob_regs #(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bob_pkg::PADDR_W-1:0]   paddr,
    input  logic [bob_pkg::CFG_W-1:0]     pwdata,
    output logic [bob_pkg::CFG_W-1:0]     prdata,
    output logic [DIM_BITS-1:0]           od [MAX_RANK],
    output logic                          err,
    output logic                          luse [MAX_RANK],
    output logic                          ruse [MAX_RANK],
    output logic [bob_pkg::IDX_W-1:0]     lstride [MAX_RANK],
    output logic [bob_pkg::IDX_W-1:0]     rstride [MAX_RANK],
    output logic [DIM_BITS*MAX_RANK-1:0]  count
);
    import bob_pkg::*;

    localparam int CNT_W = DIM_BITS * MAX_RANK;
    localparam logic [RANK_W-1:0] MAXR = RANK_W'(MAX_RANK);

    logic [CFG_W-1:0]  ldims_reg;
    logic [CFG_W-1:0]  rdims_reg;
    logic [RANK_W-1:0] lrank_reg;
    logic [RANK_W-1:0] rrank_reg;
    logic              wr;
    logic [RANK_W-1:0] lr;
    logic [RANK_W-1:0] rr;

    logic [DIM_BITS-1:0] ld_next [MAX_RANK];
    logic [DIM_BITS-1:0] rd_next [MAX_RANK];
    logic [DIM_BITS-1:0] od_next [MAX_RANK];
    logic                err_next;
    logic [DIM_BITS-1:0] ld_reg [MAX_RANK];
    logic [DIM_BITS-1:0] rd_reg [MAX_RANK];
    logic [DIM_BITS-1:0] od_reg [MAX_RANK];
    logic                luse_reg [MAX_RANK];
    logic                ruse_reg [MAX_RANK];
    logic                err_reg;
    logic [CNT_W-1:0]    cnt_reg [MAX_RANK];
    logic [IDX_W-1:0]    ls_reg [MAX_RANK];
    logic [IDX_W-1:0]    rs_reg [MAX_RANK];

    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ldims_reg <= DIMS_RESET;
            rdims_reg <= DIMS_RESET;
            lrank_reg <= '0;
            rrank_reg <= '0;
        end
        else if (wr)
        begin
            case (paddr[4:3])
                REG_LEFT_DIMS:  ldims_reg <= pwdata;
                REG_RIGHT_DIMS: rdims_reg <= pwdata;
                REG_LEFT_RANK:  lrank_reg <= pwdata[RANK_W-1:0];
                REG_RIGHT_RANK: rrank_reg <= pwdata[RANK_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_LEFT_DIMS:  prdata = ldims_reg;
            REG_RIGHT_DIMS: prdata = rdims_reg;
            REG_LEFT_RANK:  prdata = {{(CFG_W-RANK_W){1'b0}}, lrank_reg};
            REG_RIGHT_RANK: prdata = {{(CFG_W-RANK_W){1'b0}}, rrank_reg};
            default:        prdata = '0;
        endcase
    end

    assign lr = (lrank_reg > MAXR) ? MAXR : lrank_reg;
    assign rr = (rrank_reg > MAXR) ? MAXR : rrank_reg;

    // per-dimension shape, missing dims count as 1
    always_comb
    begin
        err_next = 1'b0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            ld_next[k] = (RANK_W'(k) < lr) ? ldims_reg[SLICE_W*k +: DIM_BITS]
                                           : DIM_BITS'(1);
            rd_next[k] = (RANK_W'(k) < rr) ? rdims_reg[SLICE_W*k +: DIM_BITS]
                                           : DIM_BITS'(1);
            od_next[k] = (ld_next[k] > rd_next[k]) ? ld_next[k] : rd_next[k];
            if (ld_next[k] == '0 || rd_next[k] == '0 ||
                (ld_next[k] != rd_next[k] && ld_next[k] != DIM_BITS'(1) &&
                 rd_next[k] != DIM_BITS'(1)))
                err_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0;
            for (int k = 0; k < MAX_RANK; k++)
            begin
                ld_reg[k]   <= DIM_BITS'(1);
                rd_reg[k]   <= DIM_BITS'(1);
                od_reg[k]   <= DIM_BITS'(1);
                luse_reg[k] <= 1'b0;
                ruse_reg[k] <= 1'b0;
            end
        end
        else
        begin
            err_reg <= err_next;
            for (int k = 0; k < MAX_RANK; k++)
            begin
                ld_reg[k]   <= ld_next[k];
                rd_reg[k]   <= rd_next[k];
                od_reg[k]   <= od_next[k];
                luse_reg[k] <= (ld_next[k] != DIM_BITS'(1));
                ruse_reg[k] <= (rd_next[k] != DIM_BITS'(1));
            end
        end
    end

    // running products, one multiply per stage
    genvar j;
    generate
        for (j = 0; j < MAX_RANK; j++)
        begin : g_cnt
            logic [CNT_W-1:0]          cprev;
            logic [CNT_W+DIM_BITS-1:0] cprod;
            if (j == 0)
            begin : g_first
                assign cprev = CNT_W'(1);
            end
            else
            begin : g_chain
                assign cprev = cnt_reg[j-1];
            end
            assign cprod = cprev * od_reg[j];
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    cnt_reg[j] <= CNT_W'(1);
                else
                    cnt_reg[j] <= cprod[CNT_W-1:0];
            end
        end

        for (j = 0; j < MAX_RANK; j++)
        begin : g_str
            if (j == 0)
            begin : g_unit
                assign ls_reg[j] = IDX_W'(1);
                assign rs_reg[j] = IDX_W'(1);
            end
            else
            begin : g_mul
                logic [IDX_W+DIM_BITS-1:0] lprod;
                logic [IDX_W+DIM_BITS-1:0] rprod;
                assign lprod = ((j == 1) ? IDX_W'(1) : ls_reg[j-1]) * ld_reg[j-1];
                assign rprod = ((j == 1) ? IDX_W'(1) : rs_reg[j-1]) * rd_reg[j-1];
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        ls_reg[j] <= IDX_W'(1);
                        rs_reg[j] <= IDX_W'(1);
                    end
                    else
                    begin
                        ls_reg[j] <= lprod[IDX_W-1:0];
                        rs_reg[j] <= rprod[IDX_W-1:0];
                    end
                end
            end
        end
    endgenerate

    assign od      = od_reg;
    assign err     = err_reg;
    assign luse    = luse_reg;
    assign ruse    = ruse_reg;
    assign lstride = ls_reg;
    assign rstride = rs_reg;
    assign count   = cnt_reg[MAX_RANK-1];

endmodule

>>> sv/bob_div.sv
// Pipelined restoring divider taking one coordinate off the running quotient
module bob_div #(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16,
    parameter int SLOT     = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      v_in,
    input  logic [bob_pkg::IDX_W-1:0] idx_in,
    input  logic [bob_pkg::IDX_W-1:0] quo_in,
    input  logic [DIM_BITS-1:0]       crd_in [MAX_RANK],
    input  logic [DIM_BITS-1:0]       divisor,
    input  logic                      hold_in,
    output logic                      v_out,
    output logic [bob_pkg::IDX_W-1:0] idx_out,
    output logic [bob_pkg::IDX_W-1:0] quo_out,
    output logic [DIM_BITS-1:0]       crd_out [MAX_RANK],
    output logic                      hold_out
);
    import bob_pkg::*;

    localparam int STEPS = IDX_W / STEP_BITS;

    logic                v_reg   [STEPS];
    logic [DIM_BITS-1:0] rem_reg [STEPS];
    logic [IDX_W-1:0]    q_reg   [STEPS];
    logic [IDX_W-1:0]    idx_reg [STEPS];
    logic [DIM_BITS-1:0] crd_reg [STEPS][MAX_RANK];
    logic                hold    [STEPS];

    genvar s;
    generate
        for (s = 0; s < STEPS; s++)
        begin : g_step
            logic                src_v;
            logic [DIM_BITS-1:0] src_rem;
            logic [IDX_W-1:0]    src_q;
            logic [IDX_W-1:0]    src_idx;
            logic [DIM_BITS-1:0] src_crd [MAX_RANK];
            logic [DIM_BITS-1:0] rem_next;
            logic [IDX_W-1:0]    q_next;

            if (s == 0)
            begin : g_src_in
                assign src_v   = v_in;
                assign src_rem = '0;
                assign src_q   = quo_in;
                assign src_idx = idx_in;
                assign src_crd = crd_in;
            end
            else
            begin : g_src_prev
                assign src_v   = v_reg[s-1];
                assign src_rem = rem_reg[s-1];
                assign src_q   = q_reg[s-1];
                assign src_idx = idx_reg[s-1];
                assign src_crd = crd_reg[s-1];
            end

            if (s == STEPS - 1)
            begin : g_hold_last
                assign hold[s] = v_reg[s] && hold_in;
            end
            else
            begin : g_hold_mid
                assign hold[s] = v_reg[s] && hold[s+1];
            end

            always_comb
            begin
                logic [DIM_BITS:0] part;
                rem_next = src_rem;
                q_next   = src_q;
                for (int b = 0; b < STEP_BITS; b++)
                begin
                    part   = {rem_next, q_next[IDX_W-1]};
                    q_next = {q_next[IDX_W-2:0], 1'b0};
                    if (part >= {1'b0, divisor})
                    begin
                        part      = part - {1'b0, divisor};
                        q_next[0] = 1'b1;
                    end
                    rem_next = part[DIM_BITS-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else if (!hold[s])
                    v_reg[s] <= src_v;
            end

            always_ff @(posedge clk)
            begin
                if (!hold[s])
                begin
                    rem_reg[s] <= rem_next;
                    q_reg[s]   <= q_next;
                    idx_reg[s] <= src_idx;
                    crd_reg[s] <= src_crd;
                end
            end
        end
    endgenerate

    always_comb
    begin
        crd_out       = crd_reg[STEPS-1];
        crd_out[SLOT] = rem_reg[STEPS-1];
    end

    assign v_out    = v_reg[STEPS-1];
    assign idx_out  = idx_reg[STEPS-1];
    assign quo_out  = q_reg[STEPS-1];
    assign hold_out = hold[0];

endmodule

>>> sv/bob_comb.sv
// Stride multiply, sum, range check and output register
module bob_comb #(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          v_in,
    input  logic [bob_pkg::IDX_W-1:0]     idx_in,
    input  logic [bob_pkg::IDX_W-1:0]     quo_in,
    input  logic [DIM_BITS-1:0]           crd_in [MAX_RANK],
    input  logic                          err,
    input  logic                          luse [MAX_RANK],
    input  logic                          ruse [MAX_RANK],
    input  logic [bob_pkg::IDX_W-1:0]     lstride [MAX_RANK],
    input  logic [bob_pkg::IDX_W-1:0]     rstride [MAX_RANK],
    input  logic [DIM_BITS*MAX_RANK-1:0]  count,
    input  logic                          stall,
    output logic                          valid,
    output logic [bob_pkg::IDX_W-1:0]     lhs_index,
    output logic [bob_pkg::IDX_W-1:0]     rhs_index,
    output logic                          shape_error,
    output logic                          out_of_range,
    output logic                          is_last,
    output logic                          hold_out
);
    import bob_pkg::*;

    `include "broadcast_operand_index_generator_defines.svh"

    localparam int CNT_W = DIM_BITS * MAX_RANK;
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    logic                va_reg;
    logic [IDX_W-1:0]    idxa_reg;
    logic [IDX_W-1:0]    lp_reg [MAX_RANK];
    logic [IDX_W-1:0]    rp_reg [MAX_RANK];
    logic [IDX_W-1:0]    lp_next [MAX_RANK];
    logic [IDX_W-1:0]    rp_next [MAX_RANK];
    logic                hold_a;
    logic                hold_b;

    logic                vb_reg;
    logic [IDX_W-1:0]    li_reg;
    logic [IDX_W-1:0]    ri_reg;
    logic                serr_reg;
    logic                oor_reg;
    logic                last_reg;
    logic [IDX_W-1:0]    li_next;
    logic [IDX_W-1:0]    ri_next;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic                oor;
    logic                last;

    assign hold_b   = vb_reg && stall;
    assign hold_a   = va_reg && hold_b;
    assign hold_out = hold_a;

    // outermost coordinate is the quotient left after the divider chain
    always_comb
    begin
        logic [DIM_BITS-1:0]       coord;
        logic [IDX_W+DIM_BITS-1:0] lprod;
        logic [IDX_W+DIM_BITS-1:0] rprod;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            coord = (k == MAX_RANK - 1) ? quo_in[DIM_BITS-1:0] : crd_in[k];
            lprod = coord * lstride[k];
            rprod = coord * rstride[k];
            lp_next[k] = luse[k] ? lprod[IDX_W-1:0] : '0;
            rp_next[k] = ruse[k] ? rprod[IDX_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (!hold_a)
            va_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (!hold_a)
        begin
            idxa_reg <= idx_in;
            lp_reg   <= lp_next;
            rp_reg   <= rp_next;
        end
    end

    always_comb
    begin
        li_next = '0;
        ri_next = '0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            li_next = li_next + lp_reg[k];
            ri_next = ri_next + rp_reg[k];
        end
    end

    assign idx_ext = CMP_W'(idxa_reg);
    assign cnt_ext = CMP_W'(count);
    assign oor     = (idx_ext >= cnt_ext);
    assign last    = (idx_ext == cnt_ext - CMP_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (!hold_b)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!hold_b)
        begin
            serr_reg <= err;
            oor_reg  <= !err && oor;
            last_reg <= !err && !oor && last;
            li_reg   <= (err || oor) ? '0 : li_next;
            ri_reg   <= (err || oor) ? '0 : ri_next;
        end
    end

    assign valid        = vb_reg;
    assign lhs_index    = li_reg;
    assign rhs_index    = ri_reg;
    assign shape_error  = serr_reg;
    assign out_of_range = oor_reg;
    assign is_last      = last_reg;

    `BOB_ASSERT_NOW(a_flag_zero, vb_reg && (serr_reg || oor_reg), li_reg == '0 && ri_reg == '0 && !last_reg, "flagged request carries nonzero result")
    `BOB_ASSERT_NOW(a_flag_excl, vb_reg && oor_reg, !serr_reg, "range and shape flags both set")
    `BOB_ASSERT_NEXT(a_stage_hold, va_reg && hold_b, va_reg && $stable(idxa_reg), "blocked stage lost its request")

endmodule

>>> sv/broadcast_operand_index_generator.sv
// Broadcast operand index generator top level
//
// Configuration goes in through the APB port: left and right dimensions
// (four 16-bit slices, innermost lowest) and the two ranks. Write it only
// while no request is in flight.
// Requests arrive on in_valid/in_stall with out_index; results leave on
// out_valid/out_stall with lhs_index, rhs_index and the three flags.
// A request is taken at an edge with valid high and stall low.
// The pipeline is one input register, a 4-bit-per-stage divider of
// 12 stages for each inner dimension, then a stride multiply stage and
// a sum/compare stage.
// Throughput is one request per cycle while out_stall is low.
// When the receiver stalls the result holds in the output register; earlier
// stages keep filling any empty slot until the pipeline is full, then
// in_stall rises.
// Reset empties the pipeline and returns the registers to unit shapes of
// rank zero.
module broadcast_operand_index_generator #(
    parameter int MAX_RANK = bob_pkg::MAX_RANK_DEF,
    parameter int DIM_BITS = bob_pkg::DIM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bob_pkg::PADDR_W-1:0]   paddr,
    input  logic [bob_pkg::CFG_W-1:0]     pwdata,
    output logic [bob_pkg::CFG_W-1:0]     prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bob_pkg::IDX_W-1:0]     out_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bob_pkg::IDX_W-1:0]     lhs_index,
    output logic [bob_pkg::IDX_W-1:0]     rhs_index,
    output logic                          shape_error,
    output logic                          out_of_range,
    output logic                          is_last
);
    import bob_pkg::*;

    localparam int NDIV = MAX_RANK - 1;

    logic [DIM_BITS-1:0]       od [MAX_RANK];
    logic                      err;
    logic                      luse [MAX_RANK];
    logic                      ruse [MAX_RANK];
    logic [IDX_W-1:0]          lstride [MAX_RANK];
    logic [IDX_W-1:0]          rstride [MAX_RANK];
    logic [DIM_BITS*MAX_RANK-1:0] count;

    logic                v0_reg;
    logic [IDX_W-1:0]    idx0_reg;
    logic                ch_v    [NDIV+1];
    logic [IDX_W-1:0]    ch_idx  [NDIV+1];
    logic [IDX_W-1:0]    ch_quo  [NDIV+1];
    logic [DIM_BITS-1:0] ch_crd  [NDIV+1][MAX_RANK];
    logic                ch_hold [NDIV+1];
    logic                hold0;

    assign pready = 1'b1;

    bob_regs #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .od      (od),
        .err     (err),
        .luse    (luse),
        .ruse    (ruse),
        .lstride (lstride),
        .rstride (rstride),
        .count   (count)
    );

    assign hold0    = v0_reg && ch_hold[0];
    assign in_stall = hold0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (!hold0)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!hold0)
            idx0_reg <= out_index;
    end

    always_comb
    begin
        ch_v[0]   = v0_reg;
        ch_idx[0] = idx0_reg;
        ch_quo[0] = idx0_reg;
        for (int k = 0; k < MAX_RANK; k++)
            ch_crd[0][k] = '0;
    end

    genvar j;
    generate
        for (j = 0; j < NDIV; j++)
        begin : g_div
            bob_div #(
                .MAX_RANK (MAX_RANK),
                .DIM_BITS (DIM_BITS),
                .SLOT     (j)
            ) u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .v_in     (ch_v[j]),
                .idx_in   (ch_idx[j]),
                .quo_in   (ch_quo[j]),
                .crd_in   (ch_crd[j]),
                .divisor  (od[j]),
                .hold_in  (ch_hold[j+1]),
                .v_out    (ch_v[j+1]),
                .idx_out  (ch_idx[j+1]),
                .quo_out  (ch_quo[j+1]),
                .crd_out  (ch_crd[j+1]),
                .hold_out (ch_hold[j])
            );
        end
    endgenerate

    bob_comb #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_comb (
        .clk          (clk),
        .rst_n        (rst_n),
        .v_in         (ch_v[NDIV]),
        .idx_in       (ch_idx[NDIV]),
        .quo_in       (ch_quo[NDIV]),
        .crd_in       (ch_crd[NDIV]),
        .err          (err),
        .luse         (luse),
        .ruse         (ruse),
        .lstride      (lstride),
        .rstride      (rstride),
        .count        (count),
        .stall        (out_stall),
        .valid        (out_valid),
        .lhs_index    (lhs_index),
        .rhs_index    (rhs_index),
        .shape_error  (shape_error),
        .out_of_range (out_of_range),
        .is_last      (is_last),
        .hold_out     (ch_hold[NDIV])
    );

endmodule
